// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SRNG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRNG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRNG_ASSERT(name, prop, msg)
`define SRNG_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- hdl/srng_pkg.sv -----
// ----------------------------------------------------------------------------
// srng_pkg
// Shared constants, codes and types of the sequenced sample ring.
// ----------------------------------------------------------------------------
`default_nettype none

package srng_pkg;

  localparam int unsigned RING_DEPTH = 32768;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned SERIES_MAX = 4096;
  localparam int unsigned BATCH_CAP  = 64;

  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned ID_W       = 12;
  localparam int unsigned STAMP_W    = 63;
  localparam int unsigned BITS_W     = 32;
  localparam int unsigned WANT_W     = 16;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SCNT_W     = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned S_TDATA_W  = 192;
  localparam int unsigned M_TDATA_W  = 240;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_POLL  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_ENABLED = 2'd0,
    CFG_SERIES_COUNT = 2'd1,
    CFG_BATCH_MAX    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC_A,
    S_CALC_B,
    S_CALC_C,
    S_CALC_D,
    S_CALC_E,
    S_READ,
    S_SEND,
    S_EMPTY
  } srng_state_e;

  typedef struct packed {
    logic write;
    logic poll_load;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic calc_d;
    logic calc_e;
    logic rd_en;
    logic out_sample;
    logic out_empty;
  } srng_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_one;
    logic out_free;
  } srng_sts_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [ID_W-1:0]    series;
    logic [STAMP_W-1:0] stamp;
    logic [BITS_W-1:0]  bits;
  } slot_t;

endpackage

`default_nettype wire

// ----- hdl/srng_ctrl.sv -----
// ----------------------------------------------------------------------------
// srng_ctrl
// Sequencer: takes writes and polls, steps the poll setup and the readout.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module srng_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  func_i,
  output logic                       s_tready_o,
  input  wire srng_pkg::srng_sts_t   sts_i,
  output srng_pkg::srng_cmd_t        cmd_o
);

  srng_pkg::srng_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srng_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      srng_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (func_i == srng_pkg::FUNC_POLL) begin
            cmd_o.poll_load = 1'b1;
            state_d         = srng_pkg::S_CALC_A;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      srng_pkg::S_CALC_A: begin
        cmd_o.calc_a = 1'b1;
        state_d      = srng_pkg::S_CALC_B;
      end
      srng_pkg::S_CALC_B: begin
        cmd_o.calc_b = 1'b1;
        state_d      = srng_pkg::S_CALC_C;
      end
      srng_pkg::S_CALC_C: begin
        cmd_o.calc_c = 1'b1;
        state_d      = srng_pkg::S_CALC_D;
      end
      srng_pkg::S_CALC_D: begin
        cmd_o.calc_d = 1'b1;
        state_d      = srng_pkg::S_CALC_E;
      end
      srng_pkg::S_CALC_E: begin
        if (sts_i.empty) begin
          state_d = srng_pkg::S_EMPTY;
        end else begin
          cmd_o.calc_e = 1'b1;
          state_d      = srng_pkg::S_READ;
        end
      end
      srng_pkg::S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = srng_pkg::S_SEND;
      end
      srng_pkg::S_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_sample = 1'b1;
          state_d          = sts_i.last_one ? srng_pkg::S_IDLE : srng_pkg::S_READ;
        end
      end
      srng_pkg::S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_empty = 1'b1;
          state_d         = srng_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = srng_pkg::S_IDLE;
      end
    endcase
  end

  `SRNG_ASSERT(a_busy_no_take, (state_q != srng_pkg::S_IDLE) |-> (!cmd_o.write && !cmd_o.poll_load), "transaction taken while busy")
  `SRNG_ASSERT_NEXT(a_send_moves, (state_q == srng_pkg::S_SEND) && sts_i.out_free, (state_q == srng_pkg::S_READ) || (state_q == srng_pkg::S_IDLE), "send stuck with free output")

endmodule

`default_nettype wire

// ----- hdl/srng_dp.sv -----
// ----------------------------------------------------------------------------
// srng_dp
// Datapath: configuration, write counter, sample memory, poll arithmetic
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module srng_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  input  wire logic [srng_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [srng_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [srng_pkg::ID_W-1:0]          in_series_i,
  input  wire logic [srng_pkg::STAMP_W-1:0]       in_stamp_i,
  input  wire logic [srng_pkg::BITS_W-1:0]        in_bits_i,
  input  wire logic [srng_pkg::SEQ_W-1:0]         in_after_i,
  input  wire logic [srng_pkg::WANT_W-1:0]        in_want_i,
  input  wire srng_pkg::srng_cmd_t                cmd_i,
  output srng_pkg::srng_sts_t                     sts_o,
  input  wire logic                               m_tready_i,
  output logic                                    out_valid_o,
  output logic                                    out_has_o,
  output logic [srng_pkg::SEQ_W-1:0]              out_seq_o,
  output logic [srng_pkg::ID_W-1:0]               out_series_o,
  output logic [srng_pkg::STAMP_W-1:0]            out_stamp_o,
  output logic [srng_pkg::BITS_W-1:0]             out_bits_o,
  output logic [srng_pkg::SEQ_W-1:0]              out_cursor_o,
  output logic                                    out_ovr_o,
  output logic                                    out_last_o
);

  localparam int unsigned CW = srng_pkg::CNT_W;

  logic                           ring_en_q;
  logic [srng_pkg::SCNT_W-1:0]    series_cnt_q;
  logic [CW-1:0]                  bmax_q;
  logic [srng_pkg::SEQ_W-1:0]     wc_q;

  logic [srng_pkg::SCNT_W-1:0]    series_lim;
  logic                           wr_ok;
  logic [CW-1:0]                  bmax_eff;
  logic [CW-1:0]                  want_eff;
  srng_pkg::slot_t                wr_slot;

  srng_pkg::slot_t                mem [srng_pkg::RING_DEPTH];
  srng_pkg::slot_t                rd_q;

  logic [srng_pkg::SEQ_W-1:0]     after_q, start_q, newest_q, oldest_q, span_q;
  logic [srng_pkg::SEQ_W-1:0]     cursor_q, seq_q;
  logic [CW-1:0]                  want_q, remain_q;
  logic                           ovr_q, none_q, empty_q;

  logic [srng_pkg::SEQ_W:0]       diff;
  logic [CW-2:0]                  want_m1;
  logic                           span_ge;
  logic [CW-2:0]                  cnt_m1;
  logic [CW-1:0]                  cnt;

  logic                           out_valid_q, out_has_q, out_ovr_q, out_last_q;
  logic [srng_pkg::SEQ_W-1:0]     out_seq_q, out_cursor_q;
  logic [srng_pkg::ID_W-1:0]      out_series_q;
  logic [srng_pkg::STAMP_W-1:0]   out_stamp_q;
  logic [srng_pkg::BITS_W-1:0]    out_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_en_q    <= 1'b1;
      series_cnt_q <= '0;
      bmax_q       <= CW'(srng_pkg::BATCH_CAP);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srng_pkg::CFG_RING_ENABLED: ring_en_q    <= cfg_data_i[0];
        srng_pkg::CFG_SERIES_COUNT: series_cnt_q <= cfg_data_i;
        srng_pkg::CFG_BATCH_MAX:    bmax_q       <= cfg_data_i[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign series_lim = (series_cnt_q > srng_pkg::SCNT_W'(srng_pkg::SERIES_MAX))
                    ? srng_pkg::SCNT_W'(srng_pkg::SERIES_MAX) : series_cnt_q;
  assign wr_ok = cmd_i.write && ring_en_q && ({1'b0, in_series_i} < series_lim);
  assign wr_slot = '{seq: wc_q, series: in_series_i, stamp: in_stamp_i, bits: in_bits_i};

  always_comb begin
    if (bmax_q == '0) begin
      bmax_eff = CW'(1);
    end else if (bmax_q > CW'(srng_pkg::BATCH_CAP)) begin
      bmax_eff = CW'(srng_pkg::BATCH_CAP);
    end else begin
      bmax_eff = bmax_q;
    end
    if (in_want_i == '0 || in_want_i > srng_pkg::WANT_W'(bmax_eff)) begin
      want_eff = bmax_eff;
    end else begin
      want_eff = in_want_i[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= srng_pkg::SEQ_W'(1);
    end else if (wr_ok) begin
      wc_q <= wc_q + srng_pkg::SEQ_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wc_q[srng_pkg::RING_AW-1:0]] <= wr_slot;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[seq_q[srng_pkg::RING_AW-1:0]];
    end
  end

  assign diff    = {1'b0, newest_q} - {1'b0, start_q};
  assign want_m1 = (CW-1)'(want_q - CW'(1));
  assign span_ge = (span_q[srng_pkg::SEQ_W-1:CW-1] != '0) || (span_q[CW-2:0] >= want_m1);
  assign cnt_m1  = span_ge ? want_m1 : span_q[CW-2:0];
  assign cnt     = CW'(cnt_m1) + CW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.poll_load) begin
      after_q <= in_after_i;
      want_q  <= want_eff;
      ovr_q   <= 1'b0;
    end
    if (cmd_i.calc_a) begin
      start_q  <= after_q + srng_pkg::SEQ_W'(1);
      newest_q <= wc_q - srng_pkg::SEQ_W'(1);
      none_q   <= (wc_q[srng_pkg::SEQ_W-1:1] == '0);
    end
    if (cmd_i.calc_b) begin
      oldest_q <= (newest_q[srng_pkg::SEQ_W-1:srng_pkg::RING_AW] != '0)
                ? newest_q - srng_pkg::SEQ_W'(srng_pkg::RING_DEPTH - 1)
                : srng_pkg::SEQ_W'(1);
    end
    if (cmd_i.calc_c && (start_q < oldest_q)) begin
      start_q <= oldest_q;
      ovr_q   <= 1'b1;
    end
    if (cmd_i.calc_d) begin
      span_q  <= diff[srng_pkg::SEQ_W-1:0];
      empty_q <= none_q || diff[srng_pkg::SEQ_W];
    end
    if (cmd_i.calc_e) begin
      cursor_q <= start_q + srng_pkg::SEQ_W'(cnt_m1);
      remain_q <= cnt;
      seq_q    <= start_q;
    end
    if (cmd_i.out_sample) begin
      seq_q    <= seq_q + srng_pkg::SEQ_W'(1);
      remain_q <= remain_q - CW'(1);
    end
  end

  assign sts_o.empty    = empty_q;
  assign sts_o.last_one = (remain_q == CW'(1));
  assign sts_o.out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_sample || cmd_i.out_empty) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_sample) begin
      out_has_q    <= 1'b1;
      out_seq_q    <= seq_q;
      out_series_q <= rd_q.series;
      out_stamp_q  <= rd_q.stamp;
      out_bits_q   <= rd_q.bits;
      out_cursor_q <= cursor_q;
      out_ovr_q    <= ovr_q;
      out_last_q   <= (remain_q == CW'(1));
    end else if (cmd_i.out_empty) begin
      out_has_q    <= 1'b0;
      out_seq_q    <= '0;
      out_series_q <= '0;
      out_stamp_q  <= '0;
      out_bits_q   <= '0;
      out_cursor_q <= after_q;
      out_ovr_q    <= ovr_q && !none_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_has_o    = out_has_q;
  assign out_seq_o    = out_seq_q;
  assign out_series_o = out_series_q;
  assign out_stamp_o  = out_stamp_q;
  assign out_bits_o   = out_bits_q;
  assign out_cursor_o = out_cursor_q;
  assign out_ovr_o    = out_ovr_q;
  assign out_last_o   = out_last_q;

  `SRNG_ASSERT_NEXT(a_wc_step, wr_ok, wc_q == $past(wc_q) + srng_pkg::SEQ_W'(1), "write counter did not advance")
  `SRNG_ASSERT_NEXT(a_empty_out, cmd_i.out_empty, out_valid_q && out_last_q && !out_has_q, "empty poll result malformed")
  `SRNG_ASSERT_NEXT(a_last_out, cmd_i.out_sample && (remain_q == CW'(1)), out_valid_q && out_last_q && out_has_q, "final sample not marked last")

endmodule

`default_nettype wire

// ----- hdl/sequenced_sample_ring_core.sv -----
// ----------------------------------------------------------------------------
// sequenced_sample_ring_core
// Trace ring that numbers stored samples and returns them to cursor polls.
// ----------------------------------------------------------------------------
//  port group   dir  handshake          content
//  s_t*         in   tvalid/tready      write or poll transaction, tuser = func
//  m_t*         out  tvalid/tready      poll result, tuser = has_sample, tlast
//  cfg_*        in   valid/ready        register index and write data
//
//  One write can be accepted every cycle while no poll is in progress.
//  A poll steps through the setup states CALC_A to CALC_E, then loads the
//  memory read register and then the output register for each returned
//  sample; an empty poll emits its single result after the setup states.
//  The sample memory is not cleared; reset restores registers and counter only.
//  A stalled output holds the sequencer; the input is taken only between polls.
// ----------------------------------------------------------------------------
`default_nettype none

module sequenced_sample_ring_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // series[11:0], stamp_us[74:12], sample_bits[106:75],
  // poll_cursor[170:107], want_count[186:171], zero pad
  input  wire logic [srng_pkg::S_TDATA_W-1:0]      s_tdata_i,
  // func[0]
  input  wire logic                                s_tuser_i,
  input  wire logic                                s_tvalid_i,
  output logic                                     s_tready_o,
  // out_seq[63:0], out_series[75:64], out_stamp_us[138:76], out_bits[170:139],
  // cursor_out[234:171], overrun[235], zero pad
  output logic [srng_pkg::M_TDATA_W-1:0]           m_tdata_o,
  // has_sample[0]
  output logic                                     m_tuser_o,
  output logic                                     m_tlast_o,
  output logic                                     m_tvalid_o,
  input  wire logic                                m_tready_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [srng_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [srng_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  srng_pkg::srng_cmd_t               cmd;
  srng_pkg::srng_sts_t               sts;
  logic [srng_pkg::SEQ_W-1:0]        out_seq, out_cursor;
  logic [srng_pkg::ID_W-1:0]         out_series;
  logic [srng_pkg::STAMP_W-1:0]      out_stamp;
  logic [srng_pkg::BITS_W-1:0]       out_bits;
  logic                              out_ovr;

  assign cfg_ready_o = 1'b1;

  srng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .func_i     (s_tuser_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srng_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_series_i  (s_tdata_i[11:0]),
    .in_stamp_i   (s_tdata_i[74:12]),
    .in_bits_i    (s_tdata_i[106:75]),
    .in_after_i   (s_tdata_i[170:107]),
    .in_want_i    (s_tdata_i[186:171]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .m_tready_i   (m_tready_i),
    .out_valid_o  (m_tvalid_o),
    .out_has_o    (m_tuser_o),
    .out_seq_o    (out_seq),
    .out_series_o (out_series),
    .out_stamp_o  (out_stamp),
    .out_bits_o   (out_bits),
    .out_cursor_o (out_cursor),
    .out_ovr_o    (out_ovr),
    .out_last_o   (m_tlast_o)
  );

  assign m_tdata_o = {4'b0, out_ovr, out_cursor, out_bits, out_stamp, out_series, out_seq};

endmodule

`default_nettype wire

// ----- tb/sequenced_sample_ring_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequenced_sample_ring_core_checker
// Passive checker for the sequenced sample ring. It tracks register writes and
// accepted write and poll transactions on its own copy of the ring. From that
// copy it builds the result transactions each poll must return. Each result
// taken from the master side is compared field by field with the oldest
// expected one.
// ----------------------------------------------------------------------------

module sequenced_sample_ring_core_checker
  import srng_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [S_TDATA_W-1:0]   s_tdata_i,
  input  wire logic                   s_tuser_i,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [M_TDATA_W-1:0]   m_tdata_i,
  input  wire logic                   m_tuser_i,
  input  wire logic                   m_tlast_i,
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                          fail_cnt_o,
  output int                          pending_o,
  output logic [SEQ_W-1:0]            write_seq_o
);

  localparam int unsigned IN_STAMP_LO  = ID_W;
  localparam int unsigned IN_BITS_LO   = IN_STAMP_LO + STAMP_W;
  localparam int unsigned IN_AFTER_LO  = IN_BITS_LO + BITS_W;
  localparam int unsigned IN_WANT_LO   = IN_AFTER_LO + SEQ_W;
  localparam int unsigned OUT_SER_LO   = SEQ_W;
  localparam int unsigned OUT_STAMP_LO = OUT_SER_LO + ID_W;
  localparam int unsigned OUT_BITS_LO  = OUT_STAMP_LO + STAMP_W;
  localparam int unsigned OUT_CUR_LO   = OUT_BITS_LO + BITS_W;
  localparam int unsigned OUT_OVR      = OUT_CUR_LO + SEQ_W;

  typedef struct packed {
    logic               has;
    logic [SEQ_W-1:0]   seq;
    logic [ID_W-1:0]    series;
    logic [STAMP_W-1:0] stamp;
    logic [BITS_W-1:0]  bits;
    logic [SEQ_W-1:0]   cursor;
    logic               overrun;
    logic               last;
  } poll_result_t;

  logic               ring_on;
  logic [SCNT_W-1:0]  series_reg;
  logic [CNT_W-1:0]   batch_reg;
  logic [SEQ_W-1:0]   seq_ctr;
  slot_t              ring_mem [RING_DEPTH];
  poll_result_t       result_q [$];
  poll_result_t       head_r;

  initial fail_cnt_o = 0;

  task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                 input logic [SEQ_W-1:0] want);
    $display("%0t ns  ring check: %s got %h expected %h", $time, what, got, want);
    fail_cnt_o++;
  endtask

  task automatic check_field(input string what, input logic [SEQ_W-1:0] got,
                             input logic [SEQ_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic void push_empty(input logic [SEQ_W-1:0] cursor, input logic ovr);
    poll_result_t r;
    r = '0;
    r.cursor  = cursor;
    r.overrun = ovr;
    r.last    = 1'b1;
    result_q = {result_q, r};
  endfunction

  function automatic void store_sample(input logic [S_TDATA_W-1:0] d);
    logic [ID_W-1:0] id;
    int unsigned     lim;
    slot_t           s;
    id  = d[ID_W-1:0];
    lim = (series_reg > SERIES_MAX) ? SERIES_MAX : int'(series_reg);
    if (!ring_on || id >= lim) return;
    s.seq    = seq_ctr;
    s.series = id;
    s.stamp  = d[IN_STAMP_LO +: STAMP_W];
    s.bits   = d[IN_BITS_LO +: BITS_W];
    ring_mem[seq_ctr[RING_AW-1:0]] = s;
    seq_ctr = seq_ctr + 1'b1;
  endfunction

  function automatic void expect_poll(input logic [S_TDATA_W-1:0] d);
    logic [SEQ_W-1:0]  after;
    logic [SEQ_W-1:0]  newest;
    logic [SEQ_W-1:0]  oldest;
    logic [SEQ_W-1:0]  first;
    logic [SEQ_W-1:0]  stop;
    logic [SEQ_W-1:0]  seq;
    logic [WANT_W-1:0] want;
    logic [CNT_W-1:0]  cap;
    logic              ovr;
    int                n;
    slot_t             s;
    poll_result_t      batch [BATCH_CAP];
    after = d[IN_AFTER_LO +: SEQ_W];
    want  = d[IN_WANT_LO +: WANT_W];
    cap   = batch_reg;
    if (cap == 0) cap = 1;
    if (cap > BATCH_CAP) cap = BATCH_CAP;
    if (want == 0 || want > cap) want = cap;
    ovr = 1'b0;
    n   = 0;
    if (seq_ctr <= 1) begin
      push_empty(after, 1'b0);
      return;
    end
    newest = seq_ctr - 1'b1;
    oldest = (newest >= RING_DEPTH) ? newest - RING_DEPTH + 1'b1 : 64'd1;
    first  = after + 1'b1;
    if (first < oldest) begin
      first = oldest;
      ovr   = 1'b1;
    end
    if (first > newest) begin
      push_empty(after, ovr);
      return;
    end
    stop = (newest - first >= want - 1'b1) ? first + want - 1'b1 : newest;
    for (int k = 0; k <= int'(stop - first); k++) begin
      seq = first + k;
      s   = ring_mem[seq[RING_AW-1:0]];
      if (s.seq == seq && n < BATCH_CAP) begin
        batch[n] = '{has: 1'b1, seq: seq, series: s.series, stamp: s.stamp, bits: s.bits,
                     cursor: stop, overrun: ovr, last: 1'b0};
        n++;
      end
    end
    if (n == 0) begin
      push_empty(stop, ovr);
      return;
    end
    batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) result_q = {result_q, batch[k]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_on    = 1'b1;
      series_reg = '0;
      batch_reg  = CNT_W'(BATCH_CAP);
      seq_ctr    = 64'd1;
      result_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result transaction with none expected, out_seq",
                          m_tdata_i[SEQ_W-1:0], '0);
        end else begin
          head_r = result_q.pop_front();
          check_field("has_sample", m_tuser_i, head_r.has);
          check_field("out_seq", m_tdata_i[SEQ_W-1:0], head_r.seq);
          check_field("out_series", m_tdata_i[OUT_SER_LO +: ID_W], head_r.series);
          check_field("out_stamp_us", m_tdata_i[OUT_STAMP_LO +: STAMP_W], head_r.stamp);
          check_field("out_bits", m_tdata_i[OUT_BITS_LO +: BITS_W], head_r.bits);
          check_field("cursor_out", m_tdata_i[OUT_CUR_LO +: SEQ_W], head_r.cursor);
          check_field("overrun", m_tdata_i[OUT_OVR], head_r.overrun);
          check_field("tdata pad", m_tdata_i[M_TDATA_W-1:OUT_OVR+1], '0);
          check_field("last", m_tlast_i, head_r.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_RING_ENABLED: ring_on    = cfg_data_i[0];
          CFG_SERIES_COUNT: series_reg = cfg_data_i[SCNT_W-1:0];
          CFG_BATCH_MAX:    batch_reg  = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (func_e'(s_tuser_i) == FUNC_POLL) expect_poll(s_tdata_i);
        else store_sample(s_tdata_i);
      end
    end
    pending_o   = result_q.size();
    write_seq_o = seq_ctr;
  end

endmodule

// ----- tb/sequenced_sample_ring_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequenced_sample_ring_core_tb
// Stimulus and verdict for the sequenced sample ring. A directed opening covers
// empty rings, cursor extremes and field extremes. Random write and poll
// traffic follows under several register settings and idle patterns. It
// includes a long output stall. The checker instance does all prediction and
// comparison.
// ----------------------------------------------------------------------------

module sequenced_sample_ring_core_tb;
  import srng_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int STALL_LIMIT   = 5000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 16;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic [S_TDATA_W-1:0]   s_tdata_i   = '0;
  logic                   s_tuser_i   = 1'b0;
  logic                   s_tvalid_i  = 1'b0;
  logic                   s_tready_o;
  logic [M_TDATA_W-1:0]   m_tdata_o;
  logic                   m_tuser_o;
  logic                   m_tlast_o;
  logic                   m_tvalid_o;
  logic                   m_tready_i  = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  int                     fail_cnt;
  int                     pending_cnt;
  logic [SEQ_W-1:0]       write_seq;
  int                     tx_idle_pct  = 25;
  int                     rx_idle_pct  = 88;
  int                     hold_req     = 0;
  int                     hold_done    = 0;
  int                     quiet_cycles = 0;
  int unsigned            series_limit = 0;

  always #HALF_PERIOD clk_i = ~clk_i;

  sequenced_sample_ring_core dut (.*);

  sequenced_sample_ring_core_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_i  (s_tready_o),
    .m_tdata_i   (m_tdata_o),
    .m_tuser_i   (m_tuser_o),
    .m_tlast_i   (m_tlast_o),
    .m_tvalid_i  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt),
    .write_seq_o (write_seq)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sequenced_sample_ring_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold off the result side for a long stretch on request, else stall at random
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_done) begin
        m_tready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_done = hold_req;
      end else begin
        m_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [SEQ_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_item(
    input logic [ID_W-1:0] id, input logic [STAMP_W-1:0] stamp,
    input logic [BITS_W-1:0] bits, input logic [SEQ_W-1:0] after,
    input logic [WANT_W-1:0] want);
    return S_TDATA_W'({want, after, bits, stamp, id});
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned lim;
    int unsigned r;
    lim = (series_limit > SERIES_MAX) ? SERIES_MAX : series_limit;
    r   = $urandom_range(0, 99);
    if (lim != 0 && r < 5) return ID_W'(lim - 1);
    if (r < 10) return ID_W'(lim);
    if (lim != 0 && r < 88) return ID_W'($urandom_range(0, lim - 1));
    return ID_W'($urandom);
  endfunction

  function automatic logic [SEQ_W-1:0] pick_cursor();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return write_seq - 1'b1 - $urandom_range(0, 70);
    if (r < 65) return '0;
    if (r < 75) return write_seq - 1'b1 + $urandom_range(0, 3);
    if (r < 88) return rnd64();
    return '1;
  endfunction

  function automatic logic [WANT_W-1:0] pick_want();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 75) return WANT_W'($urandom_range(1, 70));
    if (r < 92) return WANT_W'($urandom);
    return '1;
  endfunction

  // all stimulus tasks start and end just after a falling edge
  task automatic send_item(input func_e fn, input logic [S_TDATA_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tuser_i  <= fn;
    s_tdata_i  <= data;
    s_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_write(input logic [ID_W-1:0] id);
    send_item(FUNC_WRITE, pack_item(id, STAMP_W'(rnd64()), $urandom, rnd64(),
                                    WANT_W'($urandom)));
  endtask

  task automatic send_poll(input logic [SEQ_W-1:0] after, input logic [WANT_W-1:0] want);
    send_item(FUNC_POLL, pack_item(ID_W'($urandom), STAMP_W'(rnd64()), $urandom,
                                   after, want));
  endtask

  task automatic run_traffic(input int count, input int poll_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < poll_pct) send_poll(pick_cursor(), pick_want());
      else send_write(pick_id());
    end
  endtask

  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic enable, input logic [SCNT_W-1:0] count,
                           input logic [CNT_W-1:0] batch);
    settle();
    write_reg(CFG_RING_ENABLED, CFG_DATA_W'(enable));
    write_reg(CFG_SERIES_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_BATCH_MAX, CFG_DATA_W'(batch));
    cfg_valid_i  <= 1'b0;
    series_limit = count;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_poll('0, '0);
    send_poll('1, '1);
    send_item(FUNC_WRITE, pack_item('0, '0, '0, '1, '1));
    configure(1'b1, SCNT_W'(SERIES_MAX), CNT_W'(BATCH_CAP));
    send_item(FUNC_WRITE, pack_item('0, '0, '0, '0, '0));
    send_item(FUNC_WRITE, pack_item('1, '1, '1, '0, '0));
    repeat (8) send_write(pick_id());
    send_poll('0, '0);
    send_poll('0, WANT_W'(1));
    send_poll(SEQ_W'(3), '1);
    send_poll(SEQ_W'(10), WANT_W'(5));
    send_poll({1'b1, {(SEQ_W-1){1'b0}}}, WANT_W'(2));
    send_poll('1, WANT_W'(3));

    configure(1'b1, '1, '0);
    run_traffic(45, 30);

    tx_idle_pct = 88;
    rx_idle_pct = 25;
    configure(1'b0, SCNT_W'(100), '1);
    run_traffic(30, 30);
    configure(1'b1, SCNT_W'(1), CNT_W'(1));
    run_traffic(40, 35);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(1'b1, SCNT_W'($urandom_range(1, SERIES_MAX)),
              CNT_W'($urandom_range(1, BATCH_CAP)));
    hold_req = hold_req + 1;
    run_traffic(60, 40);

    configure(1'b1, SCNT_W'(SERIES_MAX), CNT_W'(BATCH_CAP));
    run_traffic(30, 20);
    settle();
    send_poll('0, '0);
    send_poll(write_seq - 2'd2, WANT_W'(4));
    send_poll(write_seq - 1'b1, WANT_W'(4));
    send_poll('1, '0);

    settle();
    if (fail_cnt == 0) begin
      $display("sequenced_sample_ring_core_tb: PASS");
    end else begin
      $display("sequenced_sample_ring_core_tb: FAIL");
    end
    $finish;
  end

endmodule
